@@ rtl/sha256_pkg.sv @@
// Shared constants, types and the rotate function for the SHA-256 byte hasher.
package sha256_pkg;

    localparam int WORD_W = 32;
    localparam int NUM_ROUNDS = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_byte;   // write input byte into the buffer and count it
        logic load_pad;    // write a padding byte at the fill position
        logic [1:0] pad_kind;  // selects 0x80, zero or length byte
        logic start_comp;  // copy chain into working vars, clear round count
        logic do_round;    // run one compression round
        logic fold;        // add working vars into chain, clear fill
        logic clear_all;   // return to reset values after the digest
        logic shift_out;   // advance the digest output word
    } t_cmd;

    localparam logic [1:0] PAD_MARK = 2'd0;
    localparam logic [1:0] PAD_ZERO = 2'd1;
    localparam logic [1:0] PAD_LEN  = 2'd2;

    typedef struct packed {
        logic [6:0] fill;      // bytes held in the buffer
        logic       last_round;
    } t_status;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

@@ rtl/sha256_datapath.sv @@
// Message words, bit counter, schedule window, round logic and chain words.
module sha256_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_cmd    i_cmd,
    input  logic [7:0]          i_byte,
    output sha256_pkg::t_status o_status,
    output sha256_pkg::t_word   o_digest
);
    import sha256_pkg::*;

    t_word      r_chain [8];
    t_word      r_v     [8];
    t_word      r_w     [16];
    logic [63:0] r_bits;
    logic [6:0]  r_fill;
    logic [5:0]  r_round;

    logic [7:0] wr_byte;
    logic [2:0] len_idx;
    logic [3:0] wr_word;
    logic [4:0] wr_lsb;
    t_word      w_cur, w_new, s0, s1, ch, mj, t1, t2;
    t_word      w2, w15;

    assign len_idx = r_fill[2:0];
    // byte p of the block lands big-endian in word p/4
    assign wr_word = r_fill[5:2];
    assign wr_lsb  = {~r_fill[1:0], 3'b000};

    always_comb begin
        case (i_cmd.pad_kind)
            PAD_MARK: wr_byte = PAD_BYTE;
            PAD_LEN:  wr_byte = r_bits[{~len_idx, 3'b000} +: 8];
            default:  wr_byte = 8'h00;
        endcase
    end

    // Schedule window: filled from the byte stream, then r_w[0] is word t,
    // shifted each round.
    assign w2  = r_w[14];
    assign w15 = r_w[1];
    assign w_new = (rotr(w2,17) ^ rotr(w2,19) ^ (w2 >> 10)) + r_w[9]
                 + (rotr(w15,7) ^ rotr(w15,18) ^ (w15 >> 3)) + r_w[0];
    assign w_cur = r_w[0];

    assign s1 = rotr(r_v[4],6) ^ rotr(r_v[4],11) ^ rotr(r_v[4],25);
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1 = r_v[7] + s1 + ch + ROUND_K[r_round] + w_cur;
    assign s0 = rotr(r_v[0],2) ^ rotr(r_v[0],13) ^ rotr(r_v[0],22);
    assign mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2 = s0 + mj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_w[wr_word][wr_lsb +: 8] <= i_byte;
        end else if (i_cmd.load_pad) begin
            r_w[wr_word][wr_lsb +: 8] <= wr_byte;
        end else if (i_cmd.do_round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
        if (i_cmd.start_comp) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
        end else if (i_cmd.do_round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= INIT_H[i];
            r_bits  <= '0;
            r_fill  <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.load_byte) begin
                r_bits <= r_bits + 64'd8;
                r_fill <= r_fill + 7'd1;
            end else if (i_cmd.load_pad) begin
                r_fill <= r_fill + 7'd1;
            end
            if (i_cmd.start_comp) r_round <= '0;
            else if (i_cmd.do_round) r_round <= r_round + 6'd1;
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
                r_fill <= '0;
            end
            if (i_cmd.shift_out) begin
                for (int i = 0; i < 7; i++) r_chain[i] <= r_chain[i+1];
                r_chain[7] <= r_chain[0];
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.last_round = (r_round == 6'(NUM_ROUNDS - 1));
    assign o_digest            = r_chain[0];

endmodule

@@ rtl/sha256_ctrl.sv @@
// Controller: byte intake, padding, compression rounds and digest output.
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_has_byte,
    input  logic                i_eom,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_word_num,
    input  sha256_pkg::t_status i_status,
    output sha256_pkg::t_cmd    o_cmd
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_FOLD  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_closing, n_closing;
    logic       r_padding, n_padding;
    logic       r_len_ok, n_len_ok;
    logic       r_len_done, n_len_done;
    logic [2:0] r_word, n_word;
    logic       accept;

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_closing  = r_closing;
        n_padding  = r_padding;
        n_len_ok   = r_len_ok;
        n_len_done = r_len_done;
        n_word     = r_word;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    o_cmd.load_byte = i_has_byte;
                    n_closing  = i_eom;
                    n_padding  = 1'b0;
                    n_len_ok   = 1'b0;
                    n_len_done = 1'b0;
                    if (i_has_byte || i_eom) n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // full buffer compresses; else closing writes the mark, else wait
                if (i_status.fill[6]) begin
                    o_cmd.start_comp = 1'b1;
                    n_state = ST_ROUND;
                end else if (r_closing) begin
                    o_cmd.load_pad = 1'b1;
                    o_cmd.pad_kind = PAD_MARK;
                    n_padding = 1'b1;
                    // length fits in this block only if the mark lands before byte 56
                    n_len_ok  = (i_status.fill < 7'd56);
                    n_state   = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (i_status.fill[6]) begin
                    o_cmd.start_comp = 1'b1;
                    n_len_done = r_len_ok;
                    n_len_ok   = 1'b1;
                    n_state    = ST_ROUND;
                end else begin
                    o_cmd.load_pad = 1'b1;
                    if (r_len_ok && i_status.fill[5:3] == 3'd7) begin
                        o_cmd.pad_kind = PAD_LEN;
                    end else begin
                        o_cmd.pad_kind = PAD_ZERO;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                if (i_status.last_round) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                // fold strobe is raised in this cycle by the fold stage
                if (r_len_done)     n_state = ST_OUT;
                else if (r_padding) n_state = ST_PAD;
                else                n_state = ST_CHECK;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_word = r_word + 3'd1;
                    if (r_word == 3'd7) begin
                        o_cmd.shift_out = 1'b0;
                        o_cmd.clear_all = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_closing  <= 1'b0;
            r_padding  <= 1'b0;
            r_len_ok   <= 1'b0;
            r_len_done <= 1'b0;
            r_word     <= '0;
        end else begin
            r_state    <= n_state;
            r_closing  <= n_closing;
            r_padding  <= n_padding;
            r_len_ok   <= n_len_ok;
            r_len_done <= n_len_done;
            r_word     <= n_word;
        end
    end

    assign o_out_valid = (r_state == ST_OUT);
    assign o_word_num  = r_word;

endmodule

@@ rtl/sha256_fold.sv @@
// Holds the fold strobe aligned to the cycle after the last round.
module sha256_fold (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha256_pkg::t_cmd i_cmd,
    input  logic             i_last_round,
    output sha256_pkg::t_cmd o_cmd
);
    import sha256_pkg::*;

    logic r_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fold <= 1'b0;
        else          r_fold <= i_cmd.do_round && i_last_round;
    end

    always_comb begin
        o_cmd      = i_cmd;
        o_cmd.fold = r_fold;
    end

endmodule

@@ rtl/sha256_byte_stream_hasher.sv @@
// Top level of the SHA-256 byte-stream hasher.
// SHA-256 over a byte stream: one message byte per input item (tuser bit 0
// = has_byte, tlast = end_of_message). After a byte that does not fill the
// block, the input is ready again once the fill has been checked. The byte
// that completes a 64-byte block holds the input while the fill is checked
// and the compression started, the rounds run on one shared round unit,
// the working words are folded into the chain words and the fill is checked
// again. Closing a message writes the padding one byte per cycle and runs
// one or two compressions, then the digest leaves as eight items, H0 first,
// with tuser = word number and tlast on the eighth; each word waits for
// tready. No input is taken until the eighth word is gone; the block then
// starts afresh.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_number
    output logic        m_axis_tlast    // final_word
);
    import sha256_pkg::*;

    t_cmd    ctrl_cmd, dp_cmd;
    t_status status;

    sha256_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_has_byte  (s_axis_tuser),
        .i_eom       (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_word_num  (m_axis_tuser),
        .i_status    (status),
        .o_cmd       (ctrl_cmd)
    );

    sha256_fold u_fold (
        .i_clk, .i_rst_n,
        .i_cmd        (ctrl_cmd),
        .i_last_round (status.last_round),
        .o_cmd        (dp_cmd)
    );

    sha256_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd    (dp_cmd),
        .i_byte   (s_axis_tdata),
        .o_status (status),
        .o_digest (m_axis_tdata)
    );

    assign m_axis_tlast = (m_axis_tuser == 3'd7);

    // No input is taken while the digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready)) else $error("input during output");
    // Buffer never holds more than one block.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.fill <= 7'd64) else $error("fill overflow");
    // Words leave in order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tuser == $past(m_axis_tuser) + 3'd1) else $error("word order");

endmodule
